/* hdl/linear_key_value_table_macros.svh */
// ----------------------------------------------------------------------------
// linear_key_value_table_macros.svh
// Assertion macros used by the checker file of the key/value table.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LKVT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvt check failed: same-cycle property");

// Next-cycle implication, disabled while reset is high.
`define LKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvt check failed: next-cycle property");

`endif

/* hdl/lkvt_pkg.sv */
// ----------------------------------------------------------------------------
// lkvt_pkg
// Types and constants of the linear key/value table.
// ----------------------------------------------------------------------------
package lkvt_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int LIMIT_BITS = 5;
   localparam int KIND_BITS  = 3;
   localparam int POS_BITS   = 4;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   count_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;
   typedef logic [POS_BITS-1:0]   pos_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOOKUP   = 3'd0,
      KIND_INSERT   = 3'd1,
      KIND_UPDATE   = 3'd2,
      KIND_UPSERT   = 3'd3,
      KIND_ERASE    = 3'd4,
      KIND_READ_POS = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POS,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_DONE
   } state_type;

endpackage

/* hdl/linear_key_value_table.sv */
// Linear key/value table: up to 16 key/value pairs held densely in two
// one-port-read RAMs (keys and values). Each request word is worked on alone;
// the request side is ready whenever the sequencer is idle, also while a
// response word waits in the output register. A key search reads one entry
// per cycle through the key RAM read port for lookup, insert, update,
// insert-or-update and erase; a hit ends the search at that entry, and a miss
// ends it after the last entry. Erase of a present key then fetches the last
// entry and moves it into the freed slot. Read by position reads that entry
// directly, and an unused kind or an unoccupied position goes straight to the
// response.
// ----------------------------------------------------------------------------
// linear_key_value_table
// Top level: request/response sequencer over the key and value RAMs.
// ----------------------------------------------------------------------------
module linear_key_value_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_kind,
   input  lkvt_pkg::key_type          req_key,
   input  lkvt_pkg::value_type        req_value,
   input  lkvt_pkg::pos_type          req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output lkvt_pkg::key_type          rsp_key_out,
   output lkvt_pkg::value_type        rsp_value_out,
   output lkvt_pkg::count_type        rsp_entry_count,
   output logic                       rsp_is_empty,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  lkvt_pkg::limit_type        csr_data
);
   import lkvt_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   key_type   op_key_ff, op_key_in;
   value_type op_val_ff, op_val_in;
   count_type count_ff, count_in;
   limit_type limit_ff;
   count_type iss_ff, iss_in;
   logic      pend_ff, pend_in;
   idx_type   pend_idx_ff, pend_idx_in;
   idx_type   slot_ff, slot_in;
   logic      ok_ff, ok_in;
   key_type   kout_ff, kout_in;
   value_type vout_ff, vout_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_ok_ff;
   key_type   rsp_key_ff;
   value_type rsp_val_ff;
   count_type rsp_cnt_ff;
   logic      rsp_empty_ff;
   logic      rsp_load;

   logic      rd_en;
   idx_type   rd_addr;
   logic      key_we, val_we;
   idx_type   wr_addr;
   key_type   key_wdata, key_rdata;
   value_type val_wdata, val_rdata;

   logic      req_fire, hit, miss, room, pos_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign hit    = pend_ff && (key_rdata == op_key_ff);
   assign miss   = !hit && (iss_ff >= count_ff);
   assign room   = (int'(count_ff) < int'(limit_ff)) && (int'(count_ff) < CAPACITY);
   assign pos_ok = int'(req_position) < int'(count_ff);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind inside {KIND_LOOKUP, KIND_INSERT, KIND_UPDATE,
                                    KIND_UPSERT, KIND_ERASE}) begin
                  state_in = ST_SCAN;
               end else if (req_kind == KIND_READ_POS && pos_ok) begin
                  state_in = ST_POS;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (hit && kind_ff == KIND_ERASE) begin
               state_in = ST_MOVE_RD;
            end else if (hit || miss) begin
               state_in = ST_DONE;
            end
         end
         ST_POS:     state_in = ST_DONE;
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      kind_in     = kind_ff;
      op_key_in   = op_key_ff;
      op_val_in   = op_val_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      slot_in     = slot_ff;
      ok_in       = ok_ff;
      kout_in     = kout_ff;
      vout_in     = vout_ff;
      rd_en       = 1'b0;
      rd_addr     = iss_ff[IDX_BITS-1:0];
      key_we      = 1'b0;
      val_we      = 1'b0;
      wr_addr     = count_ff[IDX_BITS-1:0];
      key_wdata   = op_key_ff;
      val_wdata   = op_val_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = kind_type'(req_kind);
               op_key_in = req_key;
               op_val_in = req_value;
               iss_in    = '0;
               ok_in     = 1'b0;
               kout_in   = req_key;
               vout_in   = '0;
               if (req_kind == KIND_READ_POS && pos_ok) begin
                  rd_en   = 1'b1;
                  rd_addr = req_position[IDX_BITS-1:0];
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               slot_in = pend_idx_ff;
               case (kind_ff)
                  KIND_LOOKUP: begin
                     ok_in   = 1'b1;
                     vout_in = val_rdata;
                  end
                  KIND_UPDATE, KIND_UPSERT: begin
                     ok_in   = 1'b1;
                     val_we  = 1'b1;
                     wr_addr = pend_idx_ff;
                  end
                  default: ;
               endcase
            end else if (miss) begin
               if ((kind_ff == KIND_INSERT || kind_ff == KIND_UPSERT) && room) begin
                  ok_in    = 1'b1;
                  key_we   = 1'b1;
                  val_we   = 1'b1;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end else begin
               // issue the next entry; its compare lands in the next cycle
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = iss_ff[IDX_BITS-1:0];
               iss_in      = iss_ff + CNT_BITS'(1);
            end
         end
         ST_POS: begin
            ok_in   = 1'b1;
            kout_in = key_rdata;
            vout_in = val_rdata;
         end
         ST_MOVE_RD: begin
            rd_en   = 1'b1;
            rd_addr = IDX_BITS'(count_ff - CNT_BITS'(1));
         end
         ST_MOVE_WR: begin
            // move the last entry into the freed slot
            key_we    = 1'b1;
            val_we    = 1'b1;
            wr_addr   = slot_ff;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
            count_in  = count_ff - CNT_BITS'(1);
            ok_in     = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      op_key_ff   <= op_key_in;
      op_val_ff   <= op_val_in;
      iss_ff      <= iss_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      ok_ff       <= ok_in;
      kout_ff     <= kout_in;
      vout_ff     <= vout_in;
      if (rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_key_ff   <= kout_ff;
         rsp_val_ff   <= vout_ff;
         rsp_cnt_ff   <= count_ff;
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   lkvt_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   lkvt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (val_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_value_out   = rsp_val_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

/* hdl/lkvt_ram.sv */
// ----------------------------------------------------------------------------
// lkvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lkvt_checker.sv */
// ----------------------------------------------------------------------------
// lkvt_checker
// Port-level checks of the linear key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_macros.svh"

module lkvt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [2:0]                 req_kind,
   input lkvt_pkg::key_type          req_key,
   input lkvt_pkg::value_type        req_value,
   input lkvt_pkg::pos_type          req_position,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_ok,
   input lkvt_pkg::key_type          rsp_key_out,
   input lkvt_pkg::value_type        rsp_value_out,
   input lkvt_pkg::count_type        rsp_entry_count,
   input logic                       rsp_is_empty,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input lkvt_pkg::limit_type        csr_data
);
   import lkvt_pkg::*;

   // a stalled response word holds
   `LKVT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ok) && $stable(rsp_key_out) && $stable(rsp_value_out) && $stable(rsp_entry_count))

   // one request word at a time
   `LKVT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   `LKVT_ASSERT_NOW(a_empty_flag, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))

   `LKVT_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, int'(rsp_entry_count) <= CAPACITY)

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (.*);
